// File: rtl/cleb_pkg.sv
package cleb_pkg;

	// ring size and derived widths
	localparam int DEPTH  = 128;
	localparam int PTR_W  = $clog2(DEPTH);
	localparam int OCC_W  = $clog2(DEPTH + 1);

	// command queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// command codes on the cmd port
	localparam logic CMD_RX   = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// special characters
	localparam logic [7:0] CH_NONE_LO = 8'h00;
	localparam logic [7:0] CH_NONE_HI = 8'hFF;
	localparam logic [7:0] CH_ERASE   = 8'h7F;
	localparam logic [7:0] CH_KILL    = 8'h15;
	localparam logic [7:0] CH_EOF     = 8'h04;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_LF      = 8'h0A;

	// erase count saturates at the field maximum
	localparam int ERASE_MAX = 255;

	// classified operation
	typedef enum logic [2:0] {
		OP_NOP,
		OP_READ,
		OP_KILL,
		OP_ERASE,
		OP_STORE
	} cleb_op_t;

	// one queued transaction
	typedef struct packed {
		cleb_op_t   op;
		logic [7:0] ch;
	} cleb_item_t;

	// back end sequencer
	typedef enum logic {
		BK_IDLE,
		BK_READ
	} cleb_bk_state_t;

endpackage

// File: rtl/cleb_front.sv
module cleb_front
	import cleb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       cmd,
	input  logic [7:0] rx_char,
	output logic       busy,
	input  logic       q_full,
	output logic       push,
	output cleb_item_t push_item
);

	logic       valid_s1;
	cleb_item_t item_s1;
	cleb_item_t item_cls;
	logic       accept;

	// classify the incoming transaction
	always_comb begin
		item_cls.op = OP_NOP;
		item_cls.ch = '0;
		if (cmd == CMD_READ) begin
			item_cls.op = OP_READ;
		end else begin
			case (rx_char) inside
				CH_NONE_LO, CH_NONE_HI: item_cls.op = OP_NOP;
				CH_KILL:                item_cls.op = OP_KILL;
				CH_ERASE:               item_cls.op = OP_ERASE;
				CH_CR: begin
					item_cls.op = OP_STORE;
					item_cls.ch = CH_LF;
				end
				default: begin
					item_cls.op = OP_STORE;
					item_cls.ch = rx_char;
				end
			endcase
		end
	end

	// stage register drains into the queue
	assign push      = valid_s1 && !q_full;
	assign busy      = valid_s1 && q_full;
	assign accept    = start && !busy;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_cls;
		end
	end

endmodule

// File: rtl/cleb_queue.sv
module cleb_queue
	import cleb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  cleb_item_t push_item,
	output logic       full,
	input  logic       pop,
	output logic       head_valid,
	output cleb_item_t head_item
);

	cleb_item_t          entry_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	function automatic logic [QPTR_W-1:0] qnext(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full       = (count_q == QCNT_W'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= qnext(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= qnext(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("queue pushed while full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue popped while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("queue count above depth");
`endif

endmodule

// File: rtl/cleb_back.sv
module cleb_back
	import cleb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  cleb_item_t head_item,
	output logic       pop,
	output logic       done,
	output logic       echo_valid,
	output logic [7:0] echo_char,
	output logic [7:0] erase_count,
	output logic       line_ready,
	output logic       read_valid,
	output logic [7:0] read_char,
	output logic       read_eof
);

	logic [7:0]       line_store [DEPTH];
	logic [PTR_W-1:0] read_ptr_q;
	logic [PTR_W-1:0] commit_ptr_q;
	logic [PTR_W-1:0] edit_ptr_q;
	logic [OCC_W-1:0] occ_q;
	cleb_bk_state_t   state_q;
	cleb_bk_state_t   state_nxt;
	logic [7:0]       rdata_q;
	logic             rd_hit_q;
	logic             rd_last_q;

	logic             done_q;
	logic             echo_valid_q;
	logic [7:0]       echo_char_q;
	logic [7:0]       erase_count_q;
	logic             line_ready_q;

	logic [PTR_W-1:0] uncommitted;
	logic [OCC_W-1:0] pending;
	logic [OCC_W-1:0] occ_inc;
	logic [31:0]      unc_wide;
	logic [7:0]       unc_sat;
	logic             can_read;
	logic             can_store;
	logic             store_commit;
	logic             do_store;
	logic             pop_other;

	function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] p);
		return (p == '0) ? PTR_W'(DEPTH - 1) : p - 1'b1;
	endfunction

	// ring bookkeeping; the edited region never holds LF, so kill erases all of it
	always_comb begin
		if (edit_ptr_q >= commit_ptr_q) begin
			uncommitted = edit_ptr_q - commit_ptr_q;
		end else begin
			uncommitted = edit_ptr_q - commit_ptr_q + PTR_W'(DEPTH);
		end
		pending      = occ_q - OCC_W'(uncommitted);
		occ_inc      = occ_q + 1'b1;
		unc_wide     = 32'(uncommitted);
		unc_sat      = (unc_wide > 32'(ERASE_MAX)) ? 8'(ERASE_MAX) : unc_wide[7:0];
		can_read     = (pending != '0);
		can_store    = (occ_q < OCC_W'(DEPTH));
		store_commit = (head_item.ch == CH_LF) || (head_item.ch == CH_EOF) ||
			(occ_inc == OCC_W'(DEPTH));
	end

	// sequencer next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			BK_IDLE: begin
				if (head_valid && head_item.op == OP_READ) begin
					state_nxt = BK_READ;
				end
			end
			BK_READ: state_nxt = BK_IDLE;
			default: state_nxt = BK_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		pop = 1'b0;
		case (state_q)
			BK_IDLE: pop = head_valid;
			BK_READ: pop = 1'b0;
			default: pop = 1'b0;
		endcase
	end

	assign pop_other = pop && (head_item.op != OP_READ);
	assign do_store  = pop && (head_item.op == OP_STORE) && can_store;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// pointer and occupancy update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_ptr_q   <= '0;
			commit_ptr_q <= '0;
			edit_ptr_q   <= '0;
			occ_q        <= '0;
			rd_hit_q     <= 1'b0;
		end else if (pop) begin
			case (head_item.op)
				OP_READ: begin
					rd_hit_q <= can_read;
					if (can_read) begin
						read_ptr_q <= ring_next(read_ptr_q);
						occ_q      <= occ_q - 1'b1;
					end
				end
				OP_KILL: begin
					edit_ptr_q <= commit_ptr_q;
					occ_q      <= occ_q - OCC_W'(uncommitted);
				end
				OP_ERASE: begin
					if (uncommitted != '0) begin
						edit_ptr_q <= ring_prev(edit_ptr_q);
						occ_q      <= occ_q - 1'b1;
					end
				end
				OP_STORE: begin
					if (can_store) begin
						edit_ptr_q <= ring_next(edit_ptr_q);
						occ_q      <= occ_inc;
						if (store_commit) begin
							commit_ptr_q <= ring_next(edit_ptr_q);
						end
					end
				end
				default: ;
			endcase
		end
	end

	// line store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (do_store) begin
			line_store[edit_ptr_q] <= head_item.ch;
		end
		if (pop && head_item.op == OP_READ) begin
			rdata_q <= line_store[read_ptr_q];
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= pop_other || (state_q == BK_READ);
		end
	end

	// result payload for edit transactions; cleared for read transactions
	always_ff @(posedge clk) begin
		if (pop_other) begin
			echo_valid_q  <= do_store;
			echo_char_q   <= do_store ? head_item.ch : 8'h00;
			line_ready_q  <= do_store && store_commit;
			erase_count_q <= 8'h00;
			if (head_item.op == OP_KILL) begin
				erase_count_q <= unc_sat;
			end else if (head_item.op == OP_ERASE && uncommitted != '0) begin
				erase_count_q <= 8'h01;
			end
		end else if (state_q == BK_READ) begin
			echo_valid_q  <= 1'b0;
			echo_char_q   <= 8'h00;
			line_ready_q  <= 1'b0;
			erase_count_q <= 8'h00;
		end
	end

	// read fields come straight from the registered store data
	assign done        = done_q;
	assign echo_valid  = echo_valid_q;
	assign echo_char   = echo_char_q;
	assign erase_count = erase_count_q;
	assign line_ready  = line_ready_q;
	assign read_valid  = done_q && rd_hit_q && (state_q == BK_IDLE) && rd_last_q;
	assign read_char   = read_valid ? rdata_q : 8'h00;
	assign read_eof    = read_valid && (rdata_q == CH_EOF);

	// marks a result that came from a read transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_last_q <= 1'b0;
		end else begin
			rd_last_q <= (state_q == BK_READ);
		end
	end

`ifndef NO_ASSERTIONS
	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(DEPTH))
		else $error("occupancy above ring size");
	a_unc_le_occ: assert property (@(posedge clk) disable iff (!arst_n)
		OCC_W'(uncommitted) <= occ_q)
		else $error("edited region larger than occupancy");
	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_READ |=> done_q && rd_last_q)
		else $error("read transaction gave no result");
	a_edit_result: assert property (@(posedge clk) disable iff (!arst_n)
		pop_other |=> done_q && !rd_last_q)
		else $error("edit transaction gave no result");
`endif

endmodule

// File: rtl/console_line_edit_buffer_core.sv
// channel   | handshake           | payload
// ----------+---------------------+------------------------------------------------
// command   | start, busy         | cmd, rx_char
// result    | done (one cycle)    | echo_valid, echo_char, erase_count, line_ready,
//           |                     | read_valid, read_char, read_eof
//
// a transaction is taken when start is high and busy is low; one result per transaction
// edit transactions execute in the back end idle state; reads also pass the read state (store read port)
// from acceptance a result passes the stage register, the queue and the done register, when idle
// a two-entry queue sits between classify and execute; busy rises only when it is full
// arst_n clears pointers, occupancy and queue; stored characters are not cleared
// results cannot be stalled: done is a single-cycle strobe
module console_line_edit_buffer_core
	import cleb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic       cmd,
	input  logic [7:0] rx_char,
	output logic       done,
	output logic       echo_valid,
	output logic [7:0] echo_char,
	output logic [7:0] erase_count,
	output logic       line_ready,
	output logic       read_valid,
	output logic [7:0] read_char,
	output logic       read_eof
);

	logic       q_full;
	logic       push;
	cleb_item_t push_item;
	logic       pop;
	logic       head_valid;
	cleb_item_t head_item;

	// accept and classify
	cleb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.rx_char   (rx_char),
		.busy      (busy),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	// decoupling queue
	cleb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	// ring and line editing
	cleb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_item   (head_item),
		.pop         (pop),
		.done        (done),
		.echo_valid  (echo_valid),
		.echo_char   (echo_char),
		.erase_count (erase_count),
		.line_ready  (line_ready),
		.read_valid  (read_valid),
		.read_char   (read_char),
		.read_eof    (read_eof)
	);

endmodule
